### src/rch_pkg.sv
// shared constants, types and helper functions for the rgb color histogram
`default_nettype none
package rch_pkg;

  localparam int CHANNEL_BITS = 5;
  localparam int COUNT_BITS   = 32;
  localparam int COMP_BITS    = 8;
  localparam int OUT_BITS     = 32;
  localparam int IDX_BITS     = 3 * CHANNEL_BITS;
  localparam int BIN_DEPTH    = 1 << IDX_BITS;
  localparam int WIDE_BITS    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [WIDE_BITS-1:0]  OUT_MAX_W = WIDE_BITS'({OUT_BITS{1'b1}});

  localparam logic [0:0] CMD_COUNT = 1'b0;
  localparam logic [0:0] CMD_READ  = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;
    logic rd_en;
    logic upd_wr;
  } rch_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
  } rch_sts_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    if (v == COUNT_MAX) begin
      r = v;
    end else begin
      r = v + count_t'(1);
    end
    return r;
  endfunction

  // clip a counter value to the output width
  function automatic logic [OUT_BITS-1:0] to_out(input count_t v);
    logic [WIDE_BITS-1:0] w;
    logic [OUT_BITS-1:0]  r;
    w = WIDE_BITS'(v);
    if (w > OUT_MAX_W) begin
      r = {OUT_BITS{1'b1}};
    end else begin
      r = w[OUT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic idx_t bin_index(input logic [COMP_BITS-1:0] r,
                                     input logic [COMP_BITS-1:0] g,
                                     input logic [COMP_BITS-1:0] b);
    return {r[COMP_BITS-1 -: CHANNEL_BITS],
            g[COMP_BITS-1 -: CHANNEL_BITS],
            b[COMP_BITS-1 -: CHANNEL_BITS]};
  endfunction

endpackage
`default_nettype wire

### src/rgb_color_histogram.sv
// rgb color histogram: 3d bin counters with saturating count and read-back
// latency: a read item's result strobes in the cycle right after the accepting edge
// items: busy holds off a new item until the last one is done; a count is a read-modify-write
// reset: a clearing pass writes zero to all 32768 bins, one per cycle, with busy high
// results cannot be stalled: out_valid is high for exactly one cycle per read item
`default_nettype none
module rgb_color_histogram (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_command,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_red,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_green,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_blue,
  output logic                                  out_valid,
  output logic      [rch_pkg::OUT_BITS-1:0]     out_bin_count,
  output logic      [rch_pkg::OUT_BITS-1:0]     out_total_pixels
);

  rch_pkg::rch_cmd_t cmd;
  rch_pkg::rch_sts_t sts;

  rch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  rch_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .sts              (sts),
    .out_bin_count    (out_bin_count),
    .out_total_pixels (out_total_pixels)
  );

`ifndef NO_ASSERTIONS
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == rch_pkg::CMD_READ) |=> out_valid)
    else $error("read item gave no result");

  a_count_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == rch_pkg::CMD_COUNT) |=> !out_valid)
    else $error("count item gave a result");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside an item");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("not busy clearing after reset");
`endif

endmodule
`default_nettype wire

### src/rch_ctrl.sv
// controller state machine: clearing pass, item acceptance and sequencing
`default_nettype none
module rch_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_command,
  input  wire rch_pkg::rch_sts_t sts,
  output rch_pkg::rch_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    cmd.clr_wr = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.upd_wr = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.rd_en = 1'b1;
          if (in_command == rch_pkg::CMD_READ) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_OUT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### src/rch_datapath.sv
// datapath: bin memory, read-modify-write, pixel total and clear counter
`default_nettype none
module rch_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rch_pkg::rch_cmd_t                cmd,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_red,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_green,
  input  wire logic [rch_pkg::COMP_BITS-1:0]    in_blue,
  output rch_pkg::rch_sts_t                     sts,
  output logic      [rch_pkg::OUT_BITS-1:0]     out_bin_count,
  output logic      [rch_pkg::OUT_BITS-1:0]     out_total_pixels
);

  rch_pkg::count_t mem [rch_pkg::BIN_DEPTH];

  rch_pkg::count_t rd_data_r;
  rch_pkg::count_t total_r;
  rch_pkg::count_t total_nxt;
  rch_pkg::idx_t   idx_r;
  rch_pkg::idx_t   clr_cnt_r;
  rch_pkg::idx_t   clr_cnt_nxt;
  rch_pkg::idx_t   rd_idx;
  rch_pkg::idx_t   wr_idx;
  rch_pkg::count_t wr_data;
  logic            wr_en;

  assign rd_idx       = rch_pkg::bin_index(in_red, in_green, in_blue);
  assign sts.clr_last = (clr_cnt_r == {rch_pkg::IDX_BITS{1'b1}});

  always_comb begin
    wr_en       = cmd.clr_wr || cmd.upd_wr;
    wr_idx      = cmd.clr_wr ? clr_cnt_r : idx_r;
    wr_data     = cmd.clr_wr ? '0 : rch_pkg::sat_inc(rd_data_r);
    clr_cnt_nxt = cmd.clr_wr ? clr_cnt_r + rch_pkg::idx_t'(1) : clr_cnt_r;
    total_nxt   = cmd.upd_wr ? rch_pkg::sat_inc(total_r) : total_r;
  end

  // single-port style bin memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx];
      idx_r     <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      total_r   <= total_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign out_bin_count    = rch_pkg::to_out(rd_data_r);
  assign out_total_pixels = rch_pkg::to_out(total_r);

endmodule
`default_nettype wire

### verif/rgb_color_histogram_tb.sv
// self-checking testbench for rgb_color_histogram: directed and random pixel counts and bin reads
module rgb_color_histogram_tb;

  localparam int          OUT_W    = rch_pkg::OUT_BITS;
  localparam int          SHIFT    = rch_pkg::COMP_BITS - rch_pkg::CHANNEL_BITS;
  localparam logic [7:0]  LOW_MASK = 8'hFF >> rch_pkg::CHANNEL_BITS;
  localparam int          N_RANDOM = 1100;

  typedef struct {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         hold;
  } pixel_item_t;

  typedef struct {
    rch_pkg::idx_t    bin;
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] total;
  } bin_readout_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             in_command = rch_pkg::CMD_COUNT;
  logic [7:0]       in_red = '0;
  logic [7:0]       in_green = '0;
  logic [7:0]       in_blue = '0;
  logic             busy;
  logic             out_valid;
  logic [OUT_W-1:0] out_bin_count;
  logic [OUT_W-1:0] out_total_pixels;

  pixel_item_t  pixel_q[$];
  bin_readout_t readout_q[$];

  rch_pkg::count_t bin_model [rch_pkg::BIN_DEPTH];
  rch_pkg::count_t total_model;

  int mismatches = 0;
  int rd_issued  = 0;
  int rd_done    = 0;
  int burst_left = 8;
  int gap_left   = 0;

  rgb_color_histogram DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_bin_count    (out_bin_count),
    .out_total_pixels (out_total_pixels)
  );

  always #2 clk = ~clk;

  function automatic rch_pkg::idx_t bin_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    return (rch_pkg::idx_t'(r >> SHIFT) << (2 * rch_pkg::CHANNEL_BITS)) |
           (rch_pkg::idx_t'(g >> SHIFT) << rch_pkg::CHANNEL_BITS) |
           rch_pkg::idx_t'(b >> SHIFT);
  endfunction

  // counters stick at all ones
  function automatic rch_pkg::count_t bump(input rch_pkg::count_t v);
    return v + rch_pkg::count_t'(v != {rch_pkg::COUNT_BITS{1'b1}});
  endfunction

  function automatic logic [OUT_W-1:0] clip_out(input rch_pkg::count_t v);
    if (rch_pkg::COUNT_BITS > OUT_W && (v >> OUT_W) != 0) begin
      return '1;
    end
    return OUT_W'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic tally_pixel(input pixel_item_t it);
    rch_pkg::idx_t b;
    bin_readout_t  ro;
    b = bin_of(it.red, it.green, it.blue);
    if (it.cmd == rch_pkg::CMD_READ) begin
      ro.bin       = b;
      ro.bin_count = clip_out(bin_model[b]);
      ro.total     = clip_out(total_model);
      readout_q.push_back(ro);
    end else begin
      bin_model[b] = bump(bin_model[b]);
      total_model  = bump(total_model);
    end
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input bit hold = 1'b0);
    pixel_item_t it;
    it.cmd   = cmd;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.hold  = hold;
    pixel_q.push_back(it);
  endtask

  // driver: bursts of items with random gaps, hold items wait for all readouts
  always @(posedge clk) begin
    logic keep;
    logic read_taken;
    keep       = 1'b0;
    read_taken = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        read_taken = (pixel_q[0].cmd == rch_pkg::CMD_READ);
        tally_pixel(pixel_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        keep = start;
      end
      if (!keep) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pixel_q.size() > 0 &&
                     (!pixel_q[0].hold || rd_issued + int'(read_taken) == rd_done)) begin
          start      <= 1'b1;
          in_command <= pixel_q[0].cmd;
          in_red     <= pixel_q[0].red;
          in_green   <= pixel_q[0].green;
          in_blue    <= pixel_q[0].blue;
        end else begin
          start <= 1'b0;
        end
      end
      if (read_taken) rd_issued <= rd_issued + 1;
    end
  end

  // monitor: every strobe must match the oldest pending readout
  always @(posedge clk) begin
    bin_readout_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (readout_q.size() == 0) begin
        report_mismatch($sformatf("result with no read pending: count %0d total %0d",
                                  out_bin_count, out_total_pixels));
      end else begin
        want = readout_q.pop_front();
        if (out_bin_count !== want.bin_count)
          report_mismatch($sformatf("bin %0h bin_count got %0d want %0d",
                                    want.bin, out_bin_count, want.bin_count));
        if (out_total_pixels !== want.total)
          report_mismatch($sformatf("bin %0h total_pixels got %0d want %0d",
                                    want.bin, out_total_pixels, want.total));
        rd_done <= rd_done + 1;
      end
    end
  end

  initial begin
    logic [23:0] palette [8];
    logic [23:0] pc;
    logic [7:0]  r, g, b;
    logic        cmd;

    foreach (bin_model[i]) bin_model[i] = '0;
    total_model = '0;

    // directed: empty bins, extremes, low bits ignored, same-bin bursts, read after count
    push_item(rch_pkg::CMD_READ,  8'h00, 8'h00, 8'h00);
    push_item(rch_pkg::CMD_READ,  8'hFF, 8'hFF, 8'hFF);
    push_item(rch_pkg::CMD_COUNT, 8'h00, 8'h00, 8'h00);
    push_item(rch_pkg::CMD_COUNT, LOW_MASK, LOW_MASK, LOW_MASK);
    push_item(rch_pkg::CMD_READ,  8'h00, 8'h00, 8'h00);
    push_item(rch_pkg::CMD_COUNT, 8'hFF, 8'hFF, 8'hFF);
    push_item(rch_pkg::CMD_COUNT, 8'hFF, 8'hFF, 8'hFF);
    push_item(rch_pkg::CMD_COUNT, 8'hFF, 8'hFF, 8'hFF);
    push_item(rch_pkg::CMD_READ,  ~LOW_MASK, ~LOW_MASK, ~LOW_MASK);
    push_item(rch_pkg::CMD_COUNT, 8'hFF, 8'h00, 8'h00);
    push_item(rch_pkg::CMD_READ,  8'hFF, 8'h00, 8'h00);
    push_item(rch_pkg::CMD_COUNT, 8'h00, 8'hFF, 8'h00);
    push_item(rch_pkg::CMD_COUNT, 8'h00, 8'h00, 8'hFF);
    push_item(rch_pkg::CMD_READ,  8'h00, 8'hFF, 8'h00);
    push_item(rch_pkg::CMD_READ,  8'h00, 8'h00, 8'hFF);
    push_item(rch_pkg::CMD_COUNT, 8'h80, 8'h40, 8'h20);
    push_item(rch_pkg::CMD_READ,  8'h87, 8'h47, 8'h27, 1'b1);
    push_item(rch_pkg::CMD_READ,  8'h55, 8'hAA, 8'h55);
    push_item(rch_pkg::CMD_COUNT, 8'hAA, 8'h55, 8'hAA);
    push_item(rch_pkg::CMD_READ,  8'hAA, 8'h55, 8'hAA, 1'b1);

    // random: mostly a small palette so bins fill up and reads hit them
    palette[0] = 24'hFFFFFF;
    palette[1] = 24'h000000;
    for (int i = 2; i < 8; i++) palette[i] = 24'($urandom);
    repeat (N_RANDOM) begin
      if ($urandom_range(0, 9) < 6) begin
        pc = palette[$urandom_range(0, 7)];
        r  = (pc[23:16] & ~LOW_MASK) | (8'($urandom) & LOW_MASK);
        g  = (pc[15:8]  & ~LOW_MASK) | (8'($urandom) & LOW_MASK);
        b  = (pc[7:0]   & ~LOW_MASK) | (8'($urandom) & LOW_MASK);
      end else begin
        {r, g, b} = 24'($urandom);
      end
      cmd = ($urandom_range(0, 99) < 35) ? rch_pkg::CMD_READ : rch_pkg::CMD_COUNT;
      push_item(cmd, r, g, b, $urandom_range(0, 149) == 0);
      if (cmd == rch_pkg::CMD_COUNT && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_item(rch_pkg::CMD_COUNT, r, g, b);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pixel_q.size() != 0 || start);
    for (int w = 0; w < 50 && rd_issued != rd_done; w++) @(negedge clk);
    if (rd_issued != rd_done)
      report_mismatch($sformatf("%0d readouts never arrived", rd_issued - rd_done));
    repeat (4) @(negedge clk);

    if (mismatches == 0) begin
      $display("rgb_color_histogram verification clean");
    end else begin
      $display("rgb_color_histogram verification failed");
    end
    $finish;
  end

  // covers the clearing pass after reset with plenty of margin
  initial begin
    #2000000;
    $display("rgb_color_histogram verification failed");
    $finish;
  end

endmodule
